@@ hdl/hps_pkg.sv @@
package hps_pkg;

   // field widths
   localparam int OP_W     = 1;
   localparam int SLOT_W   = 4;
   localparam int TIME_W   = 16;
   localparam int NOW_W    = 24;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;
   localparam int NUM_W    = NOW_W + 1;
   localparam int PROD_W   = NUM_W + TIME_W;
   localparam int DATA_W   = 32;
   localparam int ADDR_W   = 3;

   localparam int MAX_PROCS_DEFAULT = 16;

   // request opcodes
   localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
   localparam logic [OP_W-1:0] OP_PICK = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_LOADED   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_SELECTED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_WAITING  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DONE     = 2'd3;

   // register index, taken from paddr bit 2
   localparam logic REG_PROCESS_COUNT = 1'b0;

   // write and read strobes for the entry table
   typedef struct packed {
      logic load_we;
      logic clear_we;
      logic rd_en;
   } tbl_ctl_type;

   // one result
   typedef struct packed {
      logic                valid;
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   index;
      logic [TIME_W-1:0]   burst;
   } rsp_type;

endpackage

@@ hdl/hps_table.sv @@
module hps_table #(
   parameter int MAX_PROCS = hps_pkg::MAX_PROCS_DEFAULT,
   localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1
) (
   input  logic                        clock,
   input  hps_pkg::tbl_ctl_type        ctl,
   input  logic [IDX_W-1:0]            wr_addr,
   input  logic [hps_pkg::TIME_W-1:0]  wr_arrival,
   input  logic [hps_pkg::TIME_W-1:0]  wr_burst,
   input  logic [IDX_W-1:0]            rd_addr,
   output logic [hps_pkg::TIME_W-1:0]  rd_arrival,
   output logic [hps_pkg::TIME_W-1:0]  rd_burst
);
   import hps_pkg::*;

   logic [TIME_W-1:0] arrival_mem_ff [MAX_PROCS];
   logic [TIME_W-1:0] remain_mem_ff  [MAX_PROCS];
   logic [TIME_W-1:0] rd_arrival_ff;
   logic [TIME_W-1:0] rd_burst_ff;

   // write a loaded entry, or clear the burst of a picked one
   always_ff @(posedge clock) begin
      if (ctl.load_we) begin
         arrival_mem_ff[wr_addr] <= wr_arrival;
         remain_mem_ff[wr_addr]  <= wr_burst;
      end else if (ctl.clear_we) begin
         remain_mem_ff[wr_addr]  <= '0;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_arrival_ff <= arrival_mem_ff[rd_addr];
         rd_burst_ff   <= remain_mem_ff[rd_addr];
      end
   end

   assign rd_arrival = rd_arrival_ff;
   assign rd_burst   = rd_burst_ff;

endmodule

@@ hdl/hps_scan.sv @@
module hps_scan #(
   parameter int MAX_PROCS = hps_pkg::MAX_PROCS_DEFAULT,
   localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [hps_pkg::OP_W-1:0]      req_op,
   input  logic [hps_pkg::SLOT_W-1:0]    req_slot,
   input  logic [hps_pkg::TIME_W-1:0]    req_arrival_time,
   input  logic [hps_pkg::TIME_W-1:0]    req_burst_time,
   input  logic [hps_pkg::NOW_W-1:0]     req_now_time,
   input  logic [hps_pkg::COUNT_W-1:0]   process_count,
   output hps_pkg::tbl_ctl_type          tbl_ctl,
   output logic [IDX_W-1:0]              tbl_wr_addr,
   output logic [hps_pkg::TIME_W-1:0]    tbl_wr_arrival,
   output logic [hps_pkg::TIME_W-1:0]    tbl_wr_burst,
   output logic [IDX_W-1:0]              tbl_rd_addr,
   input  logic [hps_pkg::TIME_W-1:0]    tbl_rd_arrival,
   input  logic [hps_pkg::TIME_W-1:0]    tbl_rd_burst,
   output hps_pkg::rsp_type              rsp
);
   import hps_pkg::*;

   localparam int CNT_W = $clog2(MAX_PROCS + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_CMP  = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   logic [1:0]        state_ff, state_in;
   rsp_type           rsp_ff, rsp_in;
   logic [NOW_W-1:0]  now_ff, now_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              found_ff, found_in;
   logic              waiting_ff, waiting_in;
   logic [NUM_W-1:0]  best_num_ff, best_num_in;
   logic [TIME_W-1:0] best_den_ff, best_den_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [PROD_W-1:0] prod_new_ff, prod_new_in;
   logic [PROD_W-1:0] prod_best_ff, prod_best_in;
   logic [NUM_W-1:0]  cand_num_ff, cand_num_in;
   logic [TIME_W-1:0] cand_bur_ff, cand_bur_in;
   logic              cand_elig_ff, cand_elig_in;

   logic              accept;
   logic              arrived;
   logic [NOW_W-1:0]  wait_time;
   logic [NUM_W-1:0]  num;
   logic [CNT_W-1:0]  count_clip;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // clip the entry count to the table depth
   always_comb begin
      if (32'(process_count) > 32'(MAX_PROCS)) begin
         count_clip = CNT_W'(MAX_PROCS);
      end else begin
         count_clip = CNT_W'(process_count);
      end
   end

   // response ratio numerator of the entry just read
   assign arrived   = (NOW_W'(tbl_rd_arrival) <= now_ff);
   assign wait_time = now_ff - NOW_W'(tbl_rd_arrival);
   assign num       = NUM_W'(wait_time) + NUM_W'(tbl_rd_burst);

   // sequencer: load, or scan the table one entry per multiply and compare
   always_comb begin
      state_in     = state_ff;
      rsp_in       = '0;
      now_in       = now_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      waiting_in   = waiting_ff;
      best_num_in  = best_num_ff;
      best_den_in  = best_den_ff;
      best_idx_in  = best_idx_ff;
      prod_new_in  = prod_new_ff;
      prod_best_in = prod_best_ff;
      cand_num_in  = cand_num_ff;
      cand_bur_in  = cand_bur_ff;
      cand_elig_in = cand_elig_ff;
      tbl_ctl      = '0;
      tbl_wr_addr  = IDX_W'(req_slot);

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_op == OP_LOAD) begin
                  tbl_ctl.load_we = (32'(req_slot) < 32'(MAX_PROCS));
                  rsp_in.valid    = 1'b1;
                  rsp_in.status   = ST_LOADED;
               end else begin
                  now_in      = req_now_time;
                  n_in        = count_clip;
                  idx_in      = '0;
                  found_in    = 1'b0;
                  waiting_in  = 1'b0;
                  best_num_in = '0;
                  best_den_in = TIME_W'(1);
                  state_in    = S_MUL;
               end
            end
         end
         S_MUL: begin
            if (idx_ff == n_ff) begin
               state_in = S_FIN;
            end else begin
               prod_new_in  = PROD_W'(num) * PROD_W'(best_den_ff);
               prod_best_in = PROD_W'(best_num_ff) * PROD_W'(tbl_rd_burst);
               cand_num_in  = num;
               cand_bur_in  = tbl_rd_burst;
               cand_elig_in = arrived && (tbl_rd_burst != '0);
               waiting_in   = waiting_ff || !arrived;
               state_in     = S_CMP;
            end
         end
         S_CMP: begin
            if (cand_elig_ff && (!found_ff || (prod_new_ff > prod_best_ff))) begin
               found_in    = 1'b1;
               best_num_in = cand_num_ff;
               best_den_in = cand_bur_ff;
               best_idx_in = idx_ff[IDX_W-1:0];
            end
            idx_in   = idx_ff + CNT_W'(1);
            state_in = S_MUL;
         end
         S_FIN: begin
            rsp_in.valid = 1'b1;
            if (found_ff) begin
               rsp_in.status    = ST_SELECTED;
               rsp_in.index     = SLOT_W'(best_idx_ff);
               rsp_in.burst     = best_den_ff;
               tbl_ctl.clear_we = 1'b1;
               tbl_wr_addr      = best_idx_ff;
            end else if (waiting_ff) begin
               rsp_in.status = ST_WAITING;
            end else begin
               rsp_in.status = ST_DONE;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // fetch the entry that the next multiply step works on
      tbl_ctl.rd_en = (state_in == S_MUL) && (32'(idx_in) < 32'(MAX_PROCS));
   end

   assign tbl_rd_addr    = idx_in[IDX_W-1:0];
   assign tbl_wr_arrival = req_arrival_time;
   assign tbl_wr_burst   = req_burst_time;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rsp_ff   <= rsp_in;
      end
   end

   // scan payload
   always_ff @(posedge clock) begin
      now_ff       <= now_in;
      n_ff         <= n_in;
      idx_ff       <= idx_in;
      found_ff     <= found_in;
      waiting_ff   <= waiting_in;
      best_num_ff  <= best_num_in;
      best_den_ff  <= best_den_in;
      best_idx_ff  <= best_idx_in;
      prod_new_ff  <= prod_new_in;
      prod_best_ff <= prod_best_in;
      cand_num_ff  <= cand_num_in;
      cand_bur_ff  <= cand_bur_in;
      cand_elig_ff <= cand_elig_in;
   end

   assign rsp = rsp_ff;

   // finishing a scan always yields exactly one result next cycle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |=> rsp_ff.valid)
      else $error("scan finished without a result");

   // a selected entry has had its burst cleared
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ff.valid && (rsp_ff.status == ST_SELECTED)) |-> $past(tbl_ctl.clear_we))
      else $error("selection reported without clearing the entry");

   // the scan index never runs past the entry count
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (idx_ff <= n_ff))
      else $error("scan index beyond entry count");

   // a chosen entry lies inside the counted range
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_FIN) && found_ff) |-> (CNT_W'(best_idx_ff) < n_ff))
      else $error("chosen entry outside counted range");

endmodule

@@ hdl/hrrn_process_selector.sv @@
// Load request: result strobe in the cycle after accept; a new request may follow at once.
// Pick request: result strobe after the scan, next accept at the edge that ends the strobe;
//    each of the N entries, where N is process_count clipped to MAX_PROCS, costs a multiply
//    state (table read overlapped) and a compare state, then come one end-of-scan check, one
//    finish state and the result register.
// Results show for one cycle only; the receiver cannot stall. Sync reset clears process_count.
module hrrn_process_selector #(
   parameter int MAX_PROCS = hps_pkg::MAX_PROCS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [hps_pkg::OP_W-1:0]      req_op,
   input  logic [hps_pkg::SLOT_W-1:0]    req_slot,
   input  logic [hps_pkg::TIME_W-1:0]    req_arrival_time,
   input  logic [hps_pkg::TIME_W-1:0]    req_burst_time,
   input  logic [hps_pkg::NOW_W-1:0]     req_now_time,
   output logic                          rsp_valid,
   output logic [hps_pkg::STATUS_W-1:0]  rsp_status,
   output logic [hps_pkg::SLOT_W-1:0]    rsp_chosen_index,
   output logic [hps_pkg::TIME_W-1:0]    rsp_chosen_burst,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [hps_pkg::ADDR_W-1:0]    paddr,
   input  logic [hps_pkg::DATA_W-1:0]    pwdata,
   output logic [hps_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);
   import hps_pkg::*;

   localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               csr_hit;

   tbl_ctl_type        tbl_ctl;
   logic [IDX_W-1:0]   tbl_wr_addr;
   logic [TIME_W-1:0]  tbl_wr_arrival;
   logic [TIME_W-1:0]  tbl_wr_burst;
   logic [IDX_W-1:0]   tbl_rd_addr;
   logic [TIME_W-1:0]  tbl_rd_arrival;
   logic [TIME_W-1:0]  tbl_rd_burst;
   rsp_type            rsp;

   // decode the register port
   assign pready  = 1'b1;
   assign csr_hit = (paddr[2] == REG_PROCESS_COUNT);

   always_comb begin
      count_in = count_ff;
      if (psel && penable && pwrite && pready && csr_hit) begin
         count_in = pwdata[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign prdata = csr_hit ? DATA_W'(count_ff) : '0;

   hps_table #(
      .MAX_PROCS (MAX_PROCS)
   ) u_table (
      .clock      (clock),
      .ctl        (tbl_ctl),
      .wr_addr    (tbl_wr_addr),
      .wr_arrival (tbl_wr_arrival),
      .wr_burst   (tbl_wr_burst),
      .rd_addr    (tbl_rd_addr),
      .rd_arrival (tbl_rd_arrival),
      .rd_burst   (tbl_rd_burst)
   );

   hps_scan #(
      .MAX_PROCS (MAX_PROCS)
   ) u_scan (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_slot         (req_slot),
      .req_arrival_time (req_arrival_time),
      .req_burst_time   (req_burst_time),
      .req_now_time     (req_now_time),
      .process_count    (count_ff),
      .tbl_ctl          (tbl_ctl),
      .tbl_wr_addr      (tbl_wr_addr),
      .tbl_wr_arrival   (tbl_wr_arrival),
      .tbl_wr_burst     (tbl_wr_burst),
      .tbl_rd_addr      (tbl_rd_addr),
      .tbl_rd_arrival   (tbl_rd_arrival),
      .tbl_rd_burst     (tbl_rd_burst),
      .rsp              (rsp)
   );

   // drive the result ports
   assign rsp_valid        = rsp.valid;
   assign rsp_status       = rsp.status;
   assign rsp_chosen_index = rsp.index;
   assign rsp_chosen_burst = rsp.burst;

endmodule

@@ tb/testbench.sv @@
module testbench;
   import hps_pkg::*;

   localparam int TABLE_SIZE    = MAX_PROCS_DEFAULT;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_ITEMS   = 75;
   localparam logic [ADDR_W-1:0] COUNT_ADDR = {REG_PROCESS_COUNT, 2'b00};

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   index;
      logic [TIME_W-1:0]   burst;
   } pick_outcome_type;

   logic                clock;
   logic                reset            = 1'b1;
   logic                start            = 1'b0;
   logic                busy;
   logic [OP_W-1:0]     req_op           = OP_LOAD;
   logic [SLOT_W-1:0]   req_slot         = '0;
   logic [TIME_W-1:0]   req_arrival_time = '0;
   logic [TIME_W-1:0]   req_burst_time   = '0;
   logic [NOW_W-1:0]    req_now_time     = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_chosen_index;
   logic [TIME_W-1:0]   rsp_chosen_burst;
   logic                psel             = 1'b0;
   logic                penable          = 1'b0;
   logic                pwrite           = 1'b0;
   logic [ADDR_W-1:0]   paddr            = '0;
   logic [DATA_W-1:0]   pwdata           = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   // mirror of the process table and the count register
   logic [TIME_W-1:0]   arrival_mirror [TABLE_SIZE];
   logic [TIME_W-1:0]   burst_mirror   [TABLE_SIZE];
   logic [COUNT_W-1:0]  count_mirror = '0;

   pick_outcome_type pending_outcomes [$];
   int               error_count = 0;
   int               gap_percent = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   hrrn_process_selector #(.MAX_PROCS(TABLE_SIZE)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_slot(req_slot), .req_arrival_time(req_arrival_time),
      .req_burst_time(req_burst_time), .req_now_time(req_now_time),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_chosen_index(rsp_chosen_index), .rsp_chosen_burst(rsp_chosen_burst),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   task automatic report_mismatch(input string what);
      error_count++;
      $display("mismatch: %s", what);
   endtask

   // choose the highest response ratio among arrived entries, then clear its burst
   function automatic pick_outcome_type select_next_process(input logic [NOW_W-1:0] now);
      pick_outcome_type r;
      int               limit;
      int               arrived;
      bit               found;
      int               best;
      logic [63:0]      best_num;
      logic [63:0]      best_den;
      logic [63:0]      num;
      r = '{status: ST_DONE, index: '0, burst: '0};
      limit = (count_mirror > TABLE_SIZE) ? TABLE_SIZE : int'(count_mirror);
      arrived = 0;
      found = 1'b0;
      best = 0;
      best_num = '0;
      best_den = 64'd1;
      for (int i = 0; i < limit; i++) begin
         if (arrival_mirror[i] <= now) begin
            arrived++;
            if (burst_mirror[i] != '0) begin
               num = 64'(now) - 64'(arrival_mirror[i]) + 64'(burst_mirror[i]);
               // exact ratio compare; strict greater keeps the lower index on a tie
               if (!found || num * best_den > best_num * 64'(burst_mirror[i])) begin
                  found = 1'b1;
                  best = i;
                  best_num = num;
                  best_den = 64'(burst_mirror[i]);
               end
            end
         end
      end
      if (found) begin
         r.status = ST_SELECTED;
         r.index = SLOT_W'(best);
         r.burst = burst_mirror[best];
         burst_mirror[best] = '0;
      end else if (arrived < limit) begin
         r.status = ST_WAITING;
      end
      return r;
   endfunction

   // drive one request, hold it until accepted, then record what it should produce
   task automatic send_request(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                               input logic [TIME_W-1:0] arrival, input logic [TIME_W-1:0] burst,
                               input logic [NOW_W-1:0] now);
      pick_outcome_type outcome;
      if (gap_percent > 0 && $urandom_range(99) < gap_percent) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_slot <= slot;
      req_arrival_time <= arrival;
      req_burst_time <= burst;
      req_now_time <= now;
      do @(posedge clock); while (busy);
      if (op == OP_LOAD) begin
         arrival_mirror[slot] = arrival;
         burst_mirror[slot] = burst;
         outcome = '{status: ST_LOADED, index: '0, burst: '0};
      end else begin
         outcome = select_next_process(now);
      end
      pending_outcomes.push_back(outcome);
   endtask

   // hold off new requests until every result is back and the block is idle
   task automatic wait_until_idle();
      start <= 1'b0;
      while (pending_outcomes.size() != 0 || busy) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic read_process_count(output logic [DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= COUNT_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      value = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // write the count with junk in the unused bits, then read it back
   task automatic write_process_count(input logic [COUNT_W-1:0] value);
      logic [DATA_W-1:0] readback;
      wait_until_idle();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= COUNT_ADDR;
      pwdata <= ($urandom() & ~32'h1F) | DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      count_mirror = value;
      read_process_count(readback);
      if (readback !== DATA_W'(value))
         report_mismatch($sformatf("process_count read %0h, wrote %0h", readback, value));
      @(posedge clock);
   endtask

   // compare each result against the oldest outstanding request
   always @(posedge clock) begin : result_check
      pick_outcome_type want;
      if (!reset && rsp_valid) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("result with no request outstanding");
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", rsp_status, want.status));
            if (rsp_chosen_index !== want.index)
               report_mismatch($sformatf("chosen_index %0d, want %0d",
                                         rsp_chosen_index, want.index));
            if (rsp_chosen_burst !== want.burst)
               report_mismatch($sformatf("chosen_burst %0d, want %0d",
                                         rsp_chosen_burst, want.burst));
         end
      end
   end

   // count zero straight out of reset: nothing takes part, so all done
   task automatic test_count_zero();
      logic [DATA_W-1:0] value;
      read_process_count(value);
      if (value !== '0) report_mismatch($sformatf("process_count after reset %0h", value));
      @(posedge clock);
      send_request(OP_PICK, SLOT_W'($urandom()), TIME_W'($urandom()), TIME_W'($urandom()),
                   {NOW_W{1'b1}});
   endtask

   // not arrived yet, latest arrival at the last tick, then nothing left
   task automatic test_waiting_and_done();
      send_request(OP_LOAD, 4'd0, 16'd100, 16'd0, {NOW_W{1'b1}});
      send_request(OP_LOAD, 4'd1, {TIME_W{1'b1}}, {TIME_W{1'b1}}, '0);
      write_process_count(5'd2);
      send_request(OP_PICK, 4'hF, {TIME_W{1'b1}}, {TIME_W{1'b1}}, '0);
      send_request(OP_PICK, '0, '0, '0, {NOW_W{1'b1}});
      send_request(OP_PICK, '0, '0, '0, {NOW_W{1'b1}});
   endtask

   // equal ratios: the lower index must win
   task automatic test_tie_break();
      send_request(OP_LOAD, 4'd2, 16'd10, 16'd5, '0);
      send_request(OP_LOAD, 4'd3, 16'd10, 16'd5, '0);
      write_process_count(5'd4);
      send_request(OP_PICK, '0, '0, '0, 24'd20);
   endtask

   // fill the rest of the table, pick at full count and with a count above the table
   task automatic test_full_table();
      for (int s = 4; s < TABLE_SIZE; s++)
         send_request(OP_LOAD, SLOT_W'(s), TIME_W'($urandom_range(0, 1000)),
                      TIME_W'($urandom_range(1, 200)), NOW_W'($urandom()));
      write_process_count(5'd16);
      send_request(OP_PICK, '0, '0, '0, 24'd500);
      write_process_count(5'd31);
      send_request(OP_PICK, '0, '0, '0, 24'd1500);
   endtask

   // mostly loads and picks with times close together, a few at full range
   task automatic test_random_traffic(input int items);
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] burst;
      logic [NOW_W-1:0]  now;
      for (int n = 0; n < items; n++) begin
         arrival = ($urandom_range(99) < 60) ? TIME_W'($urandom_range(0, 4000))
                                             : TIME_W'($urandom());
         case ($urandom_range(9)) inside
            0:       burst = '0;
            [1:5]:   burst = TIME_W'($urandom_range(1, 64));
            default: burst = TIME_W'($urandom());
         endcase
         case ($urandom_range(19)) inside
            [0:2]:   now = NOW_W'($urandom());
            [3:5]:   now = NOW_W'($urandom_range(0, 70000));
            default: now = NOW_W'($urandom_range(0, 6000));
         endcase
         if ($urandom_range(99) < 45)
            send_request(OP_LOAD, SLOT_W'($urandom()), arrival, burst, NOW_W'($urandom()));
         else
            send_request(OP_PICK, SLOT_W'($urandom()), arrival, burst, now);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_count_zero();
      test_waiting_and_done();
      test_tie_break();
      test_full_table();

      // sender gaps: moderate, then heavy, then none; a new count each phase
      for (int p = 0; p < 6; p++) begin
         gap_percent = (p < 2) ? 35 : (p < 4) ? 67 : 0;
         case (p)
            0:       write_process_count(5'd16);
            1:       write_process_count(COUNT_W'($urandom_range(1, 15)));
            2:       write_process_count(5'd31);
            3:       write_process_count(5'd1);
            4:       write_process_count(COUNT_W'($urandom_range(2, 16)));
            default: write_process_count(COUNT_W'($urandom_range(0, 31)));
         endcase
         test_random_traffic(PHASE_ITEMS);
      end

      wait_until_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_outcomes.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_outcomes.size()));
      if (error_count == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

   // stop a hung run
   initial begin : watchdog
      int cycles;
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clock);
      $display("testbench NOT OK");
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/hps_pkg.sv
hdl/hps_table.sv
hdl/hps_scan.sv
hdl/hrrn_process_selector.sv
tb/testbench.sv
